FILE: sv/path_glob_matcher_top_assert.svh
// assertion macros shared by the matcher rtl
// no dependencies
`ifndef PATH_GLOB_MATCHER_TOP_ASSERT_SVH
`define PATH_GLOB_MATCHER_TOP_ASSERT_SVH

// same-cycle implication
`define PGM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PGM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/pgm_pkg.sv
// shared types and constants for the path glob matcher
// no dependencies
package pgm_pkg;

    localparam int PATTERN_MAX = 32;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int CLOSE_LVLS  = $clog2(PATTERN_MAX + 1);
    localparam int CFG_WORDS   = 4;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int CHAR_W      = 8;

    localparam logic [CHAR_W-1:0] STAR_CHAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] ANY_CHAR   = 8'h3F;
    localparam logic [CHAR_W-1:0] SLASH_CHAR = 8'h2F;

    typedef logic [PATTERN_MAX:0] t_pos;
    typedef logic [LEN_W-1:0]     t_len;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHARS_LOW    = 3'd0,
        REG_CHARS_SECOND = 3'd1,
        REG_CHARS_THIRD  = 3'd2,
        REG_CHARS_HIGH   = 3'd3,
        REG_LENGTH       = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        OP_CHAR = 1'b0,
        OP_END  = 1'b1
    } t_op;

    typedef struct packed {
        logic [PATTERN_MAX-1:0][CHAR_W-1:0] chars;
        t_len                               len;
    } t_pattern;

    localparam t_pos START_POS = t_pos'(1);

endpackage

FILE: sv/pgm_cfg_regs.sv
// pattern configuration registers with length clamp
// depends on pgm_pkg
module pgm_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr,
    input  logic [pgm_pkg::CFG_IDX_W-1:0]     i_index,
    input  logic [pgm_pkg::CFG_DATA_W-1:0]    i_data,
    output pgm_pkg::t_pattern                 o_pattern
);
    import pgm_pkg::*;

    logic [CFG_WORDS-1:0][CFG_DATA_W-1:0] r_words;
    logic [CFG_WORDS-1:0][CFG_DATA_W-1:0] n_words;
    t_len                                 r_len;
    t_len                                 n_len;

    always_comb begin
        n_words = r_words;
        n_len   = r_len;
        if (i_wr) begin
            case (t_cfg_idx'(i_index))
                REG_CHARS_LOW:    n_words[0] = i_data;
                REG_CHARS_SECOND: n_words[1] = i_data;
                REG_CHARS_THIRD:  n_words[2] = i_data;
                REG_CHARS_HIGH:   n_words[3] = i_data;
                REG_LENGTH:       n_len      = i_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words <= '0;
            r_len   <= '0;
        end else begin
            r_words <= n_words;
            r_len   <= n_len;
        end
    end

    assign o_pattern.chars = r_words;
    assign o_pattern.len   = (r_len > t_len'(PATTERN_MAX)) ? t_len'(PATTERN_MAX) : r_len;

endmodule

FILE: sv/pgm_step.sv
// star closure and one-character position update
// depends on pgm_pkg
module pgm_step (
    input  pgm_pkg::t_pattern            i_pattern,
    input  pgm_pkg::t_pos                i_raw,
    input  logic [pgm_pkg::CHAR_W-1:0]   i_char,
    output pgm_pkg::t_pos                o_next_raw,
    output logic                         o_matched
);
    import pgm_pkg::*;

    t_pos g [CLOSE_LVLS+1];
    t_pos p [CLOSE_LVLS+1];
    t_pos keep;
    t_pos active;
    t_pos next_raw;
    logic [PATTERN_MAX-1:0] star;
    logic not_slash;

    // parallel-prefix closure: position j inherits from j-1 across a star
    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            star[i] = (i < int'(i_pattern.len)) && (i_pattern.chars[i] == STAR_CHAR);
        end
        for (int j = 0; j <= PATTERN_MAX; j++) begin
            keep[j] = (j <= int'(i_pattern.len));
        end
        g[0] = i_raw;
        p[0] = {star, 1'b0};
        for (int l = 0; l < CLOSE_LVLS; l++) begin
            for (int j = 0; j <= PATTERN_MAX; j++) begin
                if (j >= (1 << l)) begin
                    g[l+1][j] = g[l][j] | (p[l][j] & g[l][j-(1 << l)]);
                    p[l+1][j] = p[l][j] & p[l][j-(1 << l)];
                end else begin
                    g[l+1][j] = g[l][j];
                    p[l+1][j] = p[l][j];
                end
            end
        end
        active = g[CLOSE_LVLS] & keep;
    end

    assign not_slash = (i_char != SLASH_CHAR);

    always_comb begin
        next_raw = '0;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (active[i] && (i < int'(i_pattern.len))) begin
                if (i_pattern.chars[i] == STAR_CHAR) begin
                    next_raw[i] = next_raw[i] | not_slash;
                end else if (i_pattern.chars[i] == ANY_CHAR) begin
                    next_raw[i+1] = not_slash;
                end else if (i_pattern.chars[i] == i_char) begin
                    next_raw[i+1] = 1'b1;
                end
            end
        end
    end

    assign o_next_raw = next_raw;
    assign o_matched  = active[i_pattern.len];

endmodule

FILE: sv/path_glob_matcher_top.sv
// path glob matcher: one text byte per cycle against a configured glob pattern
// end request to result valid: the input stage, then the result register
// throughput: one request per cycle; a character never waits on a stalled result
// an end request waits only while an untaken result sits in the output register
// reset: synchronous active low, pattern and length cleared, automaton at start
// depends on pgm_pkg, pgm_cfg_regs, pgm_step
module path_glob_matcher_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [7:0] text_char
    input  logic                            s_axis_tuser,  // [0] op
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,  // [0] matched, rest zero
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pgm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pgm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import pgm_pkg::*;
`include "path_glob_matcher_top_assert.svh"

    t_pattern           pattern;
    t_pos               step_next;
    logic               step_matched;
    logic               cfg_wr;
    logic               cfg_restart;
    logic               stg_go;
    logic               end_go;
    logic               end_wait;

    logic               r_stg_valid;
    t_op                r_stg_op;
    logic [CHAR_W-1:0]  r_stg_char;
    t_pos               r_active;
    logic               r_out_valid;
    logic               r_out_matched;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid & o_cfg_ready;
    // only writes to a known register restart the automaton
    assign cfg_restart = cfg_wr && (i_cfg_index inside {[REG_CHARS_LOW:REG_LENGTH]});

    pgm_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (cfg_wr),
        .i_index   (i_cfg_index),
        .i_data    (i_cfg_data),
        .o_pattern (pattern)
    );

    pgm_step u_step (
        .i_pattern  (pattern),
        .i_raw      (r_active),
        .i_char     (r_stg_char),
        .o_next_raw (step_next),
        .o_matched  (step_matched)
    );

    assign stg_go = r_stg_valid &&
                    ((r_stg_op == OP_CHAR) || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_stg_valid || stg_go;

    assign end_go   = stg_go && (r_stg_op == OP_END);
    assign end_wait = r_stg_valid && (r_stg_op == OP_END) && r_out_valid && !m_axis_tready;

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_stg_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_stg_op   <= t_op'(s_axis_tuser);
            r_stg_char <= s_axis_tdata;
        end
    end

    // position vector, kept before star closure
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= START_POS;
        end else if (cfg_restart) begin
            r_active <= START_POS;
        end else if (stg_go) begin
            r_active <= (r_stg_op == OP_END) ? START_POS : step_next;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stg_go && (r_stg_op == OP_END)) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_go && (r_stg_op == OP_END)) begin
            r_out_matched <= step_matched;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_matched};

    `PGM_ASSERT_NEXT(a_end_restarts, i_clk, i_rst_n, end_go, r_active == START_POS, "no end restart")
    `PGM_ASSERT_NEXT(a_cfg_restarts, i_clk, i_rst_n, cfg_restart, r_active == START_POS, "no cfg restart")
    `PGM_ASSERT_NEXT(a_end_gives_result, i_clk, i_rst_n, end_go, r_out_valid, "end gave no result")
    `PGM_ASSERT_NOW(a_end_stalls, i_clk, i_rst_n, end_wait, !s_axis_tready && !stg_go, "end not held")

endmodule
